FILE: hdl/sm3_pkg.sv
// Shared types, constants and helper functions of the SM3 hash engine.
// Depends on nothing; every other file but the checker imports it.
package sm3_pkg;

  localparam int WordW  = 32;
  localparam int BlkWords = 16;
  localparam int CfgIdxW = 3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_IV_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IV_AB   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IV_CD   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IV_EF   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IV_GH   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BIAS    = 3'd5;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [7:0][31:0] STD_IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  // A 512-bit block, word 0 first in message order.
  typedef logic [BlkWords-1:0][WordW-1:0] blk_t;

  // One unit of work for the compression core.
  typedef struct packed {
    blk_t blk;
    logic first;   // load the IV before compressing
    logic final_b; // emit the digest afterwards
  } job_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

FILE: hdl/sm3_hash_engine.sv
// SM3 hash engine, top level: configuration registers, front end, job queue, core.
// Uses sm3_pkg, sm3_front, sm3_job_fifo and sm3_core.
//
// Usage: message bytes enter on the in channel (in_valid/in_ready), one item
// per cycle, with has_byte marking a real byte and end_of_message closing the
// message. Bytes are packed into 64-byte blocks by the front end; each full or
// padded block goes through a two-entry job queue into the compression core.
// The core runs one SM3 round per cycle, a load step and then 64 rounds per
// block; bytes arrive at one per cycle, so the queue absorbs the extra load
// step and input stalls only briefly per block. At end of message the front
// end builds one or two padding blocks; the digest leaves on the out channel
// as four 64-bit items, part 0 first. The input is not taken after the closing
// item while the padding blocks are queued, and longer while the queue is full.
// A stalled receiver holds the current part; the core then takes no new job.
// The cfg channel (cfg_valid/cfg_ready, always ready) writes registers by
// index and should be used only while the engine is idle.
// Reset (rst, synchronous) clears the configuration registers to zero, empties
// the queue and returns both halves to idle; no clearing pass is needed.
module sm3_hash_engine import sm3_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               has_byte,
  input  logic               end_of_message,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        digest_part,
  output logic [1:0]         part_index,
  output logic               last_part,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  logic             iv_mode;
  logic [3:0][63:0] custom_iv;
  logic [63:0]      bias;
  logic             q_full, q_empty, push, pop;
  job_t             push_job, head;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      iv_mode   <= 1'b0;
      custom_iv <= '0;
      bias      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IV_MODE: iv_mode      <= cfg_data[0];
        REG_IV_AB:   custom_iv[3] <= cfg_data;
        REG_IV_CD:   custom_iv[2] <= cfg_data;
        REG_IV_EF:   custom_iv[1] <= cfg_data;
        REG_IV_GH:   custom_iv[0] <= cfg_data;
        REG_BIAS:    bias         <= cfg_data;
        default: ;
      endcase
    end
  end

  sm3_front u_front (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .has_byte, .end_of_message,
    .bias, .q_full, .push, .push_job
  );

  sm3_job_fifo u_fifo (
    .clk, .rst, .push, .push_job, .full(q_full), .pop, .empty(q_empty), .head
  );

  sm3_core u_core (
    .clk, .rst, .q_empty, .head, .pop, .iv_mode, .custom_iv,
    .out_valid, .out_ready, .digest_part, .part_index, .last_part
  );

endmodule

FILE: hdl/sm3_front.sv
// Front end: packs message bytes into blocks and builds the padding blocks.
// Uses sm3_pkg; feeds jobs to sm3_job_fifo.
module sm3_front import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  input  logic [63:0] bias,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  typedef enum logic [2:0] {
    F_ACC  = 3'b001,
    F_PAD  = 3'b010,
    F_PAD2 = 3'b100
  } fstate_t;

  fstate_t     state, state_next;
  blk_t        blk, blk_byte, padded, len_blk;
  logic [5:0]  fill;
  logic [60:0] total;
  logic        first;
  logic [63:0] len_bits;
  logic        acc;

  assign in_ready = (state == F_ACC) && !q_full;
  assign acc      = in_valid && in_ready;
  assign len_bits = {total, 3'b000} + bias;

  // Block with the incoming byte inserted at the fill position.
  always_comb begin
    blk_byte = blk;
    blk_byte[fill[5:2]][{~fill[1:0], 3'b000} +: 8] = data_byte;
  end

  // Padded last block and the length-only block.
  always_comb begin
    logic [5:0] pos;
    padded = '0;
    for (int k = 0; k < BlkWords; k++) begin
      for (int b = 0; b < 4; b++) begin
        pos = 6'(k * 4 + b);
        if (pos < fill) begin
          padded[k][(3 - b) * 8 +: 8] = blk[k][(3 - b) * 8 +: 8];
        end else if (pos == fill) begin
          padded[k][(3 - b) * 8 +: 8] = PAD_BYTE;
        end
      end
    end
    if (fill < 6'd56) begin
      padded[14] = len_bits[63:32];
      padded[15] = len_bits[31:0];
    end
    len_blk = '0;
    len_blk[14] = len_bits[63:32];
    len_blk[15] = len_bits[31:0];
  end

  // Job selection and next state.
  always_comb begin
    push       = 1'b0;
    push_job   = '{blk: blk_byte, first: first, final_b: 1'b0};
    state_next = state;
    unique case (state)
      F_ACC: begin
        if (acc && has_byte && fill == 6'd63) push = 1'b1;
        if (acc && end_of_message) state_next = F_PAD;
      end
      F_PAD: begin
        push_job = '{blk: padded, first: first, final_b: (fill < 6'd56)};
        if (!q_full) begin
          push = 1'b1;
          state_next = (fill < 6'd56) ? F_ACC : F_PAD2;
        end
      end
      F_PAD2: begin
        push_job = '{blk: len_blk, first: 1'b0, final_b: 1'b1};
        if (!q_full) begin
          push = 1'b1;
          state_next = F_ACC;
        end
      end
      default: begin
        state_next = F_ACC;
      end
    endcase
  end

  // Byte packing and message counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_ACC;
      fill  <= '0;
      total <= '0;
      first <= 1'b1;
    end else begin
      state <= state_next;
      if (acc && has_byte) begin
        blk   <= blk_byte;
        fill  <= fill + 6'd1;
        total <= total + 61'd1;
      end
      // The next message starts with a fresh IV once the digest job is queued.
      if (push) first <= push_job.final_b;
      if (push && push_job.final_b) begin
        fill  <= '0;
        total <= '0;
      end
    end
  end

endmodule

FILE: hdl/sm3_job_fifo.sv
// Two-entry job queue between the front end and the compression core.
// Uses sm3_pkg for the job type.
module sm3_job_fifo import sm3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  // Storage and pointers.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hdl/sm3_core.sv
// Compression core: 64 SM3 rounds at one per cycle, then digest output for a final job.
// Uses sm3_pkg; takes jobs from sm3_job_fifo.
module sm3_core import sm3_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  job_t               head,
  output logic               pop,
  input  logic               iv_mode,
  input  logic [3:0][63:0]   custom_iv,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        digest_part,
  output logic [1:0]         part_index,
  output logic               last_part
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_OUT  = 3'b100
  } cstate_t;

  cstate_t          state;
  logic [7:0][31:0] cv, iv;
  logic [31:0]      a, b, c, d, e, f, g, h;
  logic [15:0][31:0] w;
  logic [5:0]       round;
  logic             final_b;
  logic [1:0]       idx;
  logic [31:0]      a12, tj, ss1, ss2, ff, gg, tt1, tt2, w_new, e_new, sum1;

  // Selected initial value.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      iv[7 - i] = iv_mode ? custom_iv[3 - i / 2][(1 - i % 2) * 32 +: 32] : STD_IV[7 - i];
    end
  end

  // One compression round and one message expansion step.
  always_comb begin
    tj    = (round < 6'd16) ? T_LOW : T_HIGH;
    a12   = rotl(a, 5'd12);
    sum1  = a12 + e + rotl(tj, round[4:0]);
    ss1   = rotl(sum1, 5'd7);
    ss2   = ss1 ^ a12;
    ff    = (round < 6'd16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
    gg    = (round < 6'd16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
    tt1   = ff + d + ss2 + (w[0] ^ w[4]);
    tt2   = gg + h + ss1 + w[0];
    e_new = perm0(tt2);
    w_new = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  assign pop         = (state == C_IDLE) && !q_empty;
  assign out_valid   = (state == C_OUT);
  assign part_index  = idx;
  assign last_part   = (idx == 2'd3);
  assign digest_part = {cv[{~idx, 1'b1}], cv[{~idx, 1'b0}]};

  // Sequencer, working registers and chaining value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      round <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (!q_empty) begin
            state <= C_RUN;
            round <= '0;
          end
        end
        C_RUN: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= final_b ? C_OUT : C_IDLE;
        end
        C_OUT: begin
          if (out_ready) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
    // Datapath registers need no reset.
    if (state == C_IDLE && !q_empty) begin
      final_b <= head.final_b;
      for (int k = 0; k < BlkWords; k++) w[k] <= head.blk[k];
      if (head.first) begin
        cv <= iv;
        {a, b, c, d, e, f, g, h} <= iv;
      end else begin
        {a, b, c, d, e, f, g, h} <= cv;
      end
    end else if (state == C_RUN) begin
      for (int k = 0; k < BlkWords - 1; k++) w[k] <= w[k + 1];
      w[15] <= w_new;
      a <= tt1;
      b <= a;
      c <= rotl(b, 5'd9);
      d <= c;
      e <= e_new;
      f <= e;
      g <= rotl(f, 5'd19);
      h <= g;
      if (round == 6'd63) begin
        cv <= cv ^ {tt1, a, rotl(b, 5'd9), c, e_new, e, rotl(f, 5'd19), g};
      end
    end
  end

endmodule

FILE: hdl/sm3_checker.sv
// Port-level checks of the SM3 hash engine and the bind that attaches them.
// Depends only on the clock, reset and output channel ports of sm3_hash_engine.
module sm3_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [63:0]        digest_part,
  input logic [1:0]         part_index,
  input logic               last_part
);

  // The final flag marks exactly the fourth part.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_part == (part_index == 2'd3)))
    else $error("last_part does not match part_index");

  // Parts of a digest follow one another without a gap.
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_part |=>
      out_valid && part_index == $past(part_index) + 2'd1)
    else $error("digest parts out of sequence");

  // A stalled part holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_part) && $stable(part_index))
    else $error("stalled digest part changed");

  // Nothing is shown right after reset.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sm3_hash_engine sm3_checker u_chk (.*);
